FILE: rtl/core/pfs_pkg.sv
// Shared types, widths and constants for the polar follow speed block.
`default_nettype none

package pfs_pkg;

    localparam int XY_W       = 27;
    localparam int Z_W        = 20;
    localparam int SQ_W       = 32;
    localparam int REM_W      = 18;
    localparam int ROOT_W     = 16;
    localparam int GAIN_W     = 12;
    localparam int SQRT_STEPS = 16;

    localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;

    localparam logic REG_LINEAR_GAIN  = 1'b0;
    localparam logic REG_ANGULAR_GAIN = 1'b1;

    localparam logic [GAIN_W-1:0] LINEAR_GAIN_RESET  = 12'd128;
    localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RESET = 12'd1024;

    typedef struct packed {
        logic                     zero;
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [Z_W-1:0]    z;
        logic [SQ_W-1:0]          s;
        logic [REM_W-1:0]         r;
        logic [ROOT_W-1:0]        q;
    } lane_t;

    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] a;
        case (i)
            5'd0:    a = 17'd51472;
            5'd1:    a = 17'd30386;
            5'd2:    a = 17'd16055;
            5'd3:    a = 17'd8150;
            5'd4:    a = 17'd4091;
            5'd5:    a = 17'd2047;
            5'd6:    a = 17'd1024;
            5'd7:    a = 17'd512;
            5'd8:    a = 17'd256;
            5'd9:    a = 17'd128;
            5'd10:   a = 17'd64;
            5'd11:   a = 17'd32;
            5'd12:   a = 17'd16;
            5'd13:   a = 17'd8;
            5'd14:   a = 17'd4;
            5'd15:   a = 17'd2;
            5'd16:   a = 17'd1;
            default: a = 17'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pfs_stage.sv
// One pipeline stage: an optional CORDIC micro-rotation and an optional square-root digit.
`default_nettype none

module pfs_stage #(
    parameter int ITER      = 0,
    parameter bit DO_CORDIC = 1'b1,
    parameter bit DO_SQRT   = 1'b1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           valid_in,
    input  wire pfs_pkg::lane_t lane_in,
    output logic                valid_out,
    output pfs_pkg::lane_t      lane_out
);

    logic                                   valid_reg;
    pfs_pkg::lane_t                         lane_reg;
    pfs_pkg::lane_t                         lane_next;
    logic signed [pfs_pkg::XY_W-1:0]        xs;
    logic signed [pfs_pkg::XY_W-1:0]        ys;
    logic signed [pfs_pkg::Z_W-1:0]         a;
    logic [pfs_pkg::REM_W+1:0]              r_sh;
    logic [pfs_pkg::REM_W+1:0]              trial;

    always_comb
    begin
        lane_next = lane_in;
        xs        = lane_in.x >>> ITER;
        ys        = lane_in.y >>> ITER;
        a         = pfs_pkg::Z_W'(signed'({1'b0, pfs_pkg::atan_q16(5'(ITER))}));
        r_sh      = {lane_in.r, lane_in.s[pfs_pkg::SQ_W-1 -: 2]};
        trial     = (pfs_pkg::REM_W + 2)'({lane_in.q, 2'b01});
        if (DO_CORDIC)
        begin
            if (!lane_in.y[pfs_pkg::XY_W-1])
            begin
                lane_next.x = lane_in.x + ys;
                lane_next.y = lane_in.y - xs;
                lane_next.z = lane_in.z + a;
            end
            else
            begin
                lane_next.x = lane_in.x - ys;
                lane_next.y = lane_in.y + xs;
                lane_next.z = lane_in.z - a;
            end
        end
        if (DO_SQRT)
        begin
            lane_next.s = {lane_in.s[pfs_pkg::SQ_W-3:0], 2'b00};
            if (r_sh >= trial)
            begin
                lane_next.r = pfs_pkg::REM_W'(r_sh - trial);
                lane_next.q = {lane_in.q[pfs_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                lane_next.r = pfs_pkg::REM_W'(r_sh);
                lane_next.q = {lane_in.q[pfs_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign valid_out = valid_reg;
    assign lane_out  = lane_reg;

endmodule

`default_nettype wire

FILE: rtl/core/polar_follow_speed.sv
// Top level: offset to forward speed and turn rate through a pipelined CORDIC.
//
// Channel   Direction  Content
// s_axis    in         tdata: offset_x [15:0], offset_y [31:16]
// m_axis    out        tdata: forward_speed [15:0], turn_rate [31:16]; tuser: speed_saturated
// cfg       in         cfg_addr 0: linear_gain, 1: angular_gain
//
// One transfer is accepted per cycle while the pipeline is not held, with one stage
// per CORDIC iteration and per square-root digit.
// Reset clears all valid bits and loads the default gains.
// The whole pipeline holds while a result waits at the output and m_axis_tready is low.
`default_nettype none

module polar_follow_speed #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // offset_x [15:0], offset_y [31:16]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // forward_speed [15:0], turn_rate [31:16]
    output logic             m_axis_tuser,   // speed_saturated [0]
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [11:0] cfg_wdata
);

    localparam int LoopStages = (CORDIC_ITERATIONS > pfs_pkg::SQRT_STEPS) ?
                                CORDIC_ITERATIONS : pfs_pkg::SQRT_STEPS;

    logic [pfs_pkg::GAIN_W-1:0]         linear_gain_reg;
    logic [pfs_pkg::GAIN_W-1:0]         angular_gain_reg;

    logic                               adv;

    logic                               v0_reg;
    logic signed [15:0]                 dx_reg;
    logic signed [15:0]                 dy_reg;

    logic                               v1_reg;
    logic [31:0]                        sqx_reg;
    logic [31:0]                        sqy_reg;
    pfs_pkg::lane_t                     l1_reg;
    pfs_pkg::lane_t                     l1_next;
    logic signed [16:0]                 px;
    logic signed [16:0]                 py;

    logic                               v2_reg;
    pfs_pkg::lane_t                     l2_reg;
    pfs_pkg::lane_t                     l2_next;

    logic                               vl [0:LoopStages];
    pfs_pkg::lane_t                     lane [0:LoopStages];

    logic                               vm_reg;
    logic [27:0]                        prod_lin_reg;
    logic signed [32:0]                 prod_ang_reg;
    logic signed [pfs_pkg::Z_W-1:0]     ang;

    logic                               vo_reg;
    logic [15:0]                        speed_reg;
    logic [15:0]                        turn_reg;
    logic                               sat_reg;
    logic [28:0]                        spd_sum;
    logic [20:0]                        spd_full;
    logic signed [33:0]                 turn_sum;
    logic signed [17:0]                 turn_full;
    logic [15:0]                        speed_next;
    logic [15:0]                        turn_next;
    logic                               sat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_gain_reg  <= pfs_pkg::LINEAR_GAIN_RESET;
            angular_gain_reg <= pfs_pkg::ANGULAR_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pfs_pkg::REG_LINEAR_GAIN:  linear_gain_reg  <= cfg_wdata;
                pfs_pkg::REG_ANGULAR_GAIN: angular_gain_reg <= cfg_wdata;
                default:                   linear_gain_reg  <= linear_gain_reg;
            endcase
        end
    end

    assign adv           = !vo_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // Quadrant folding into the right half-plane and scaling for the CORDIC.
    always_comb
    begin
        px        = 17'(dx_reg);
        py        = 17'(dy_reg);
        l1_next   = '0;
        l1_next.z = '0;
        if (dx_reg < 0)
        begin
            if (dy_reg >= 0)
            begin
                px        = 17'(dy_reg);
                py        = -17'(dx_reg);
                l1_next.z = pfs_pkg::HALF_PI_Q16;
            end
            else
            begin
                px        = -17'(dy_reg);
                py        = 17'(dx_reg);
                l1_next.z = -pfs_pkg::HALF_PI_Q16;
            end
        end
        l1_next.zero = (dx_reg == 16'sd0) && (dy_reg == 16'sd0);
        l1_next.x    = {{(pfs_pkg::XY_W - 25){px[16]}}, px, 8'b0};
        l1_next.y    = {{(pfs_pkg::XY_W - 25){py[16]}}, py, 8'b0};
    end

    always_comb
    begin
        l2_next   = l1_reg;
        l2_next.s = sqx_reg + sqy_reg;
        l2_next.r = '0;
        l2_next.q = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= s_axis_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            vm_reg <= vl[LoopStages];
            vo_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg    <= s_axis_tdata[15:0];
            dy_reg    <= s_axis_tdata[31:16];
            sqx_reg   <= 32'(dx_reg * dx_reg);
            sqy_reg   <= 32'(dy_reg * dy_reg);
            l1_reg    <= l1_next;
            l2_reg    <= l2_next;
        end
    end

    assign vl[0]   = v2_reg;
    assign lane[0] = l2_reg;

    for (genvar k = 0; k < LoopStages; k++)
    begin : g_loop
        pfs_stage #(
            .ITER      (k),
            .DO_CORDIC (k < CORDIC_ITERATIONS),
            .DO_SQRT   (k < pfs_pkg::SQRT_STEPS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (vl[k]),
            .lane_in   (lane[k]),
            .valid_out (vl[k+1]),
            .lane_out  (lane[k+1])
        );
    end

    assign ang = lane[LoopStages].zero ? '0 : lane[LoopStages].z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_lin_reg <= 28'(linear_gain_reg) * 28'(lane[LoopStages].q);
            prod_ang_reg <= 33'(signed'({1'b0, angular_gain_reg})) * 33'(ang);
        end
    end

    always_comb
    begin
        spd_sum    = 29'(prod_lin_reg) + 29'd128;
        spd_full   = spd_sum[28:8];
        sat_next   = |spd_full[20:16];
        speed_next = sat_next ? 16'hFFFF : spd_full[15:0];
        turn_sum   = 34'(prod_ang_reg) + 34'sd32768;
        turn_full  = turn_sum[33:16];
        if (turn_full > 18'sd32767)
        begin
            turn_next = 16'h7FFF;
        end
        else if (turn_full < -18'sd32768)
        begin
            turn_next = 16'h8000;
        end
        else
        begin
            turn_next = turn_full[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            speed_reg <= speed_next;
            turn_reg  <= turn_next;
            sat_reg   <= sat_next;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = {turn_reg, speed_reg};
    assign m_axis_tuser  = sat_reg;

endmodule

`default_nettype wire
